// ===== hdl/lpmsh_pkg.sv =====
// ---------------------------------------------------------------------------
// Layer priority mixer package
// Shared item types, register indexes and the channel expansion table of
// the layer priority mixer with shadow and highlight.
// ---------------------------------------------------------------------------
package lpmsh_pkg;

  // Palette geometry: 64 entries of three 3-bit channels.
  localparam int unsigned PalAddrW = 6;
  localparam int unsigned PalDepth = 1 << PalAddrW;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned WordW    = 3 * ChanW;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDisplayEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBackdropIndex = 2'd1;
  localparam logic [CfgIdxW-1:0] RegShadowEnable  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLayerEnable   = 2'd3;

  // Item commands.
  localparam logic CmdComposite = 1'b0;
  localparam logic CmdPalWrite  = 1'b1;

  // Sprite operator codes in palette line 3.
  localparam logic [1:0] OpPalette   = 2'd3;
  localparam logic [3:0] OpHighlight = 4'd14;
  localparam logic [3:0] OpShadow    = 4'd15;

  // Layer enable bits.
  localparam int unsigned LayerB = 0;
  localparam int unsigned LayerA = 1;
  localparam int unsigned LayerS = 2;

  typedef struct packed {
    logic                cmd;
    logic [PalAddrW-1:0] palette_addr;
    logic [11:0]         palette_colour;
    logic [3:0]          a_index;
    logic [1:0]          a_palette;
    logic                a_priority;
    logic [3:0]          b_index;
    logic [1:0]          b_palette;
    logic                b_priority;
    logic [3:0]          s_index;
    logic [1:0]          s_palette;
    logic                s_priority;
  } lpmsh_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       drawn;
  } lpmsh_out_t;

  // Resolved pixel: chosen palette entry and its shading flags.
  typedef struct packed {
    logic [PalAddrW-1:0] entry;
    logic                dark;
    logic                bright;
    logic                drawn;
  } lpmsh_pix_t;

  // Expands a 3-bit channel to 8 bits as c * 255 / 7.
  function automatic logic [7:0] expand3(input logic [ChanW-1:0] c);
    logic [7:0] v;
    case (c)
      3'd0: v = 8'd0;
      3'd1: v = 8'd36;
      3'd2: v = 8'd72;
      3'd3: v = 8'd109;
      3'd4: v = 8'd145;
      3'd5: v = 8'd182;
      3'd6: v = 8'd218;
      3'd7: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lpmsh_resolve.sv =====
// ---------------------------------------------------------------------------
// Layer priority resolver
// Masks disabled layers, applies the shadow and highlight rules and picks
// the palette entry of the frontmost opaque pixel.
// ---------------------------------------------------------------------------
module lpmsh_resolve
  import lpmsh_pkg::*;
(
  input  lpmsh_in_t           pix_in,
  input  logic                display_enable,
  input  logic [PalAddrW-1:0] backdrop_index,
  input  logic                shadow_highlight_enable,
  input  logic [2:0]          layer_enable,
  output lpmsh_pix_t          pix_out
);

  logic [3:0] ai, bi, si;
  logic [1:0] ap, bp, sp;
  logic       apr, bpr, spr;
  logic       a_on, b_on, s_on;
  logic       s_op;
  logic       dark, bright;
  logic [PalAddrW-1:0] entry;

  // Disabled layers read as transparent.
  always_comb begin
    ai  = layer_enable[LayerA] ? pix_in.a_index    : 4'd0;
    ap  = layer_enable[LayerA] ? pix_in.a_palette  : 2'd0;
    apr = layer_enable[LayerA] ? pix_in.a_priority : 1'b0;
    bi  = layer_enable[LayerB] ? pix_in.b_index    : 4'd0;
    bp  = layer_enable[LayerB] ? pix_in.b_palette  : 2'd0;
    bpr = layer_enable[LayerB] ? pix_in.b_priority : 1'b0;
    si  = layer_enable[LayerS] ? pix_in.s_index    : 4'd0;
    sp  = layer_enable[LayerS] ? pix_in.s_palette  : 2'd0;
    spr = layer_enable[LayerS] ? pix_in.s_priority : 1'b0;
  end

  // Shadow and highlight flags; an operator sprite draws nothing.
  always_comb begin
    s_op   = shadow_highlight_enable && (sp == OpPalette) &&
             ((si == OpHighlight) || (si == OpShadow));
    dark   = 1'b0;
    bright = 1'b0;
    if (shadow_highlight_enable) begin
      dark = !(((ai != 4'd0) && apr) || ((bi != 4'd0) && bpr));
      if (s_op) begin
        if (si == OpHighlight) begin
          bright = 1'b1;
        end else begin
          dark = 1'b1;
        end
      end else if ((si != 4'd0) && spr) begin
        dark = 1'b0;
      end
    end
  end

  assign a_on = (ai != 4'd0);
  assign b_on = (bi != 4'd0);
  assign s_on = (si != 4'd0) && !s_op;

  // Back to front: backdrop, low B, A, sprite, then high B, A, sprite.
  always_comb begin
    entry = backdrop_index;
    if (b_on && !bpr) entry = {bp, bi};
    if (a_on && !apr) entry = {ap, ai};
    if (s_on && !spr) entry = {sp, si};
    if (b_on && bpr)  entry = {bp, bi};
    if (a_on && apr)  entry = {ap, ai};
    if (s_on && spr)  entry = {sp, si};
  end

  // With the display off only the plain backdrop is shown.
  always_comb begin
    if (display_enable) begin
      pix_out.entry  = entry;
      pix_out.dark   = dark;
      pix_out.bright = bright;
      pix_out.drawn  = a_on || b_on || s_on;
    end else begin
      pix_out.entry  = backdrop_index;
      pix_out.dark   = 1'b0;
      pix_out.bright = 1'b0;
      pix_out.drawn  = 1'b0;
    end
  end

endmodule

// ===== hdl/lpmsh_palette.sv =====
// ---------------------------------------------------------------------------
// Palette memory
// 64 entries of 9-bit colour with one write port and one registered read
// port. Per-entry valid bits make unwritten entries read as zero.
// ---------------------------------------------------------------------------
module lpmsh_palette
  import lpmsh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [PalAddrW-1:0] wr_addr,
  input  logic [WordW-1:0]    wr_data,
  input  logic                rd_en,
  input  logic [PalAddrW-1:0] rd_addr,
  output logic [WordW-1:0]    rd_data
);

  logic [WordW-1:0]    mem [PalDepth];
  logic [PalDepth-1:0] written;
  logic [WordW-1:0]    rd_word;
  logic                rd_ok;

  // Storage array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
      rd_ok   <= written[rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_word : '0;

endmodule

// ===== hdl/lpmsh_shade.sv =====
// ---------------------------------------------------------------------------
// Colour expander and shader
// Expands each 3-bit channel to 8 bits and applies shadow or highlight.
// ---------------------------------------------------------------------------
module lpmsh_shade
  import lpmsh_pkg::*;
(
  input  logic [WordW-1:0] word,
  input  logic             dark,
  input  logic             bright,
  input  logic             drawn,
  output lpmsh_out_t       pixel
);

  function automatic logic [7:0] shade(input logic [7:0] c, input logic d,
                                       input logic b);
    logic [7:0] v;
    if (d == b) begin
      v = c;
    end else if (d) begin
      v = {1'b0, c[7:1]};
    end else begin
      v = {1'b1, c[7:1]};
    end
    return v;
  endfunction

  // Word layout is blue, green, red from the top.
  always_comb begin
    pixel.red   = shade(expand3(word[ChanW-1:0]), dark, bright);
    pixel.green = shade(expand3(word[2*ChanW-1:ChanW]), dark, bright);
    pixel.blue  = shade(expand3(word[3*ChanW-1:2*ChanW]), dark, bright);
    pixel.drawn = drawn;
  end

endmodule

// ===== hdl/layer_priority_mixer_shadow_highlight.sv =====
// ---------------------------------------------------------------------------
// Layer priority mixer with shadow and highlight
// Composites one pixel of plane A, plane B and sprite per pixel item.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_item) carries either a pixel
//   to composite or a palette write. A palette write updates the palette
//   at its accept edge and yields no result. A pixel item yields one result
//   item on the output channel (out_valid, out_stall, out_item).
//   At the accept edge the resolved entry is read from the palette into a
//   register; the expanded and shaded colour is then loaded into the
//   output register, which raises out_valid, once it is empty or passes on.
//   One item is accepted every cycle while in_stall is low; a palette
//   write may be followed by a pixel that uses it in the very next cycle.
//   When the receiver stalls, the output register holds its item and the
//   palette read stage fills; once both are full, in_stall rises.
//   Reset empties the pipeline, clears the palette to black and loads the
//   register defaults (display off, backdrop 0, shading off, all layers on).
//   Registers are written through cfg_write, cfg_index and cfg_data; the
//   user must write them only while the block is idle (not enforced here).
// ---------------------------------------------------------------------------
module layer_priority_mixer_shadow_highlight
  import lpmsh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpmsh_in_t           in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lpmsh_out_t          out_item
);

  logic                display_enable;
  logic [PalAddrW-1:0] backdrop_index;
  logic                shadow_highlight_enable;
  logic [2:0]          layer_enable;

  lpmsh_pix_t       pix;
  logic             in_accept;
  logic             s1_advance;
  logic             out_load;
  logic             s1_valid;
  logic             s1_dark;
  logic             s1_bright;
  logic             s1_drawn;
  logic [WordW-1:0] s1_word;
  lpmsh_out_t       shaded;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable          <= 1'b0;
      backdrop_index          <= '0;
      shadow_highlight_enable <= 1'b0;
      layer_enable            <= 3'd7;
    end else if (cfg_write) begin
      case (cfg_index)
        RegDisplayEnable: display_enable          <= cfg_data[0];
        RegBackdropIndex: backdrop_index          <= cfg_data[PalAddrW-1:0];
        RegShadowEnable:  shadow_highlight_enable <= cfg_data[0];
        RegLayerEnable:   layer_enable            <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Handshake: the read stage moves when it is empty or passes its item on.
  assign out_load   = s1_valid && (!out_valid || !out_stall);
  assign s1_advance = !s1_valid || out_load;
  assign in_stall   = !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  lpmsh_resolve u_resolve (
    .pix_in                  (in_item),
    .display_enable          (display_enable),
    .backdrop_index          (backdrop_index),
    .shadow_highlight_enable (shadow_highlight_enable),
    .layer_enable            (layer_enable),
    .pix_out                 (pix)
  );

  lpmsh_palette u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_accept && (in_item.cmd == CmdPalWrite)),
    .wr_addr (in_item.palette_addr),
    .wr_data ({in_item.palette_colour[11:9], in_item.palette_colour[7:5],
               in_item.palette_colour[3:1]}),
    .rd_en   (in_accept && (in_item.cmd == CmdComposite)),
    .rd_addr (pix.entry),
    .rd_data (s1_word)
  );

  // Palette read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_valid && (in_item.cmd == CmdComposite);
    end
  end

  // Shading flags travel alongside the palette read.
  always_ff @(posedge clk) begin
    if (in_accept && (in_item.cmd == CmdComposite)) begin
      s1_dark   <= pix.dark;
      s1_bright <= pix.bright;
      s1_drawn  <= pix.drawn;
    end
  end

  lpmsh_shade u_shade (
    .word   (s1_word),
    .dark   (s1_dark),
    .bright (s1_bright),
    .drawn  (s1_drawn),
    .pixel  (shaded)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= shaded;
    end
  end

endmodule

// ===== dv/tb_layer_priority_mixer_shadow_highlight.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Layer priority mixer testbench
// Drives palette writes and pixel items into the mixer and keeps its own
// copy of the palette and registers. Each composited pixel is predicted
// and compared field by field with the result items, with random idling
// on both channels across several register settings.
// ---------------------------------------------------------------------------
module tb_layer_priority_mixer_shadow_highlight;
  import lpmsh_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned PhaseItems  = 45;

  // Mirror of the mixer: registers, palette and the pixels still to come.
  class composite_checker;
    logic       disp_on;
    logic [5:0] backdrop;
    logic       shade_on;
    logic [2:0] layers;
    logic [8:0] colour_ram [PalDepth];
    lpmsh_out_t expected_pixels [$];
    int unsigned errors;

    function new();
      disp_on  = 1'b0;
      backdrop = '0;
      shade_on = 1'b0;
      layers   = 3'd7;
      foreach (colour_ram[i]) colour_ram[i] = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegDisplayEnable: disp_on  = val[0];
        RegBackdropIndex: backdrop = val[5:0];
        RegShadowEnable:  shade_on = val[0];
        RegLayerEnable:   layers   = val[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned pixels_outstanding();
      return expected_pixels.size();
    endfunction

    // A 3-bit channel scaled to the full 8-bit range.
    function logic [7:0] widen(logic [2:0] c);
      int unsigned v;
      v = 32'(c) * 32'd255 / 32'd7;
      return v[7:0];
    endfunction

    function logic [7:0] tint(logic [7:0] c, logic dark, logic bright);
      if (dark == bright) begin
        return c;
      end else if (dark) begin
        return c >> 1;
      end else begin
        return (c >> 1) + 8'd128;
      end
    endfunction

    // Resolves one pixel item against the current palette and registers.
    function lpmsh_out_t composite_pixel(lpmsh_in_t it);
      lpmsh_out_t px;
      logic [3:0] ai, bi, si;
      logic [1:0] ap, bp, sp;
      logic       apr, bpr, spr;
      logic       dark, bright;
      logic [5:0] entry;
      logic [8:0] word;
      if (!disp_on) begin
        word = colour_ram[backdrop];
        px.red   = widen(word[2:0]);
        px.green = widen(word[5:3]);
        px.blue  = widen(word[8:6]);
        px.drawn = 1'b0;
        return px;
      end
      {ai, ap, apr} = layers[LayerA] ? {it.a_index, it.a_palette, it.a_priority} : 7'd0;
      {bi, bp, bpr} = layers[LayerB] ? {it.b_index, it.b_palette, it.b_priority} : 7'd0;
      {si, sp, spr} = layers[LayerS] ? {it.s_index, it.s_palette, it.s_priority} : 7'd0;
      dark   = 1'b0;
      bright = 1'b0;
      // Shadow unless a plane shows priority; operator sprites draw nothing.
      if (shade_on) begin
        dark = !((ai != 0 && apr) || (bi != 0 && bpr));
        if (si != 0 && sp == OpPalette && si >= OpHighlight) begin
          if (si == OpHighlight) begin
            bright = 1'b1;
          end else begin
            dark = 1'b1;
          end
          si = '0;
        end else if (si != 0 && spr) begin
          dark = 1'b0;
        end
      end
      // Back to front: low priority B, A, S then high priority B, A, S.
      entry = backdrop;
      if (bi != 0 && !bpr) entry = {bp, bi};
      if (ai != 0 && !apr) entry = {ap, ai};
      if (si != 0 && !spr) entry = {sp, si};
      if (bi != 0 && bpr)  entry = {bp, bi};
      if (ai != 0 && apr)  entry = {ap, ai};
      if (si != 0 && spr)  entry = {sp, si};
      word = colour_ram[entry];
      px.red   = tint(widen(word[2:0]), dark, bright);
      px.green = tint(widen(word[5:3]), dark, bright);
      px.blue  = tint(widen(word[8:6]), dark, bright);
      px.drawn = (ai != 0 || bi != 0 || si != 0);
      return px;
    endfunction

    // An accepted item either loads the palette or queues one pixel.
    function void note_input(lpmsh_in_t it);
      if (it.cmd == CmdPalWrite) begin
        colour_ram[it.palette_addr] = {it.palette_colour[11:9], it.palette_colour[7:5],
                                       it.palette_colour[3:1]};
      end else begin
        expected_pixels.push_back(composite_pixel(it));
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(lpmsh_out_t got);
      lpmsh_out_t exp_px;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %h with no pixel pending", got));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (got.red !== exp_px.red || got.green !== exp_px.green ||
            got.blue !== exp_px.blue || got.drawn !== exp_px.drawn) begin
          report($sformatf("rgb %h %h %h drawn %b, predicted %h %h %h drawn %b",
                           got.red, got.green, got.blue, got.drawn,
                           exp_px.red, exp_px.green, exp_px.blue, exp_px.drawn));
        end
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  lpmsh_in_t           in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lpmsh_out_t          out_item;

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count = 0;
  composite_checker sb;

  layer_priority_mixer_shadow_highlight dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshake monitor and run limit, sampled at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_layer_priority_mixer_shadow_highlight NOT OK");
      $finish;
    end else if (!rst && sb != null) begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(input logic disp, input logic [5:0] bd, input logic sh,
                               input logic [2:0] lay);
    write_reg(RegDisplayEnable, CfgDataW'(disp));
    write_reg(RegBackdropIndex, CfgDataW'(bd));
    write_reg(RegShadowEnable, CfgDataW'(sh));
    write_reg(RegLayerEnable, CfgDataW'(lay));
  endtask

  // Offers one item, idling first at the current rate, and waits for accept.
  task automatic send_item(input lpmsh_in_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits for every predicted pixel, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pixels_outstanding() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic lpmsh_in_t pal_write(input logic [5:0] addr, input logic [11:0] colour);
    lpmsh_in_t it;
    it = '0;
    it.cmd = CmdPalWrite;
    it.palette_addr = addr;
    it.palette_colour = colour;
    return it;
  endfunction

  // Each layer is given as {index, palette, priority}.
  function automatic lpmsh_in_t pixel(input logic [6:0] a, input logic [6:0] b,
                                      input logic [6:0] s);
    lpmsh_in_t it;
    it = '0;
    it.cmd = CmdComposite;
    {it.a_index, it.a_palette, it.a_priority} = a;
    {it.b_index, it.b_palette, it.b_priority} = b;
    {it.s_index, it.s_palette, it.s_priority} = s;
    return it;
  endfunction

  // Random item: mostly pixels, some operator sprites, some palette writes.
  function automatic lpmsh_in_t random_item();
    logic [$bits(lpmsh_in_t)-1:0] raw;
    lpmsh_in_t it;
    raw = $bits(lpmsh_in_t)'({$urandom, $urandom});
    it = raw;
    it.cmd = ($urandom_range(99) < 15) ? CmdPalWrite : CmdComposite;
    if (it.cmd == CmdComposite && $urandom_range(3) == 0) begin
      it.s_palette = OpPalette;
      it.s_index = $urandom_range(1) ? OpHighlight : OpShadow;
    end
    return it;
  endfunction

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Display off after reset: black backdrop, then a white one.
    send_item(pixel(7'h7F, 7'h7F, 7'h7F));
    send_item(pal_write(6'd0, 12'hFFF));
    send_item(pixel(7'h7F, 7'h7F, 7'h7F));
    wait_idle();

    // Priority order with shading off.
    apply_setting(1'b1, 6'd63, 1'b0, 3'd7);
    send_item(pal_write(6'd63, 12'h2A4));
    send_item(pal_write(6'h15, 12'h0E0));
    send_item(pal_write(6'h27, 12'hE00));
    send_item(pal_write(6'h3E, 12'h00E));
    send_item(pal_write(6'h09, 12'hEEE));
    send_item(pixel(7'h00, 7'h00, 7'h00));
    send_item(pixel(7'h00, {4'd5, 2'd1, 1'b0}, 7'h00));
    send_item(pixel({4'd7, 2'd2, 1'b0}, {4'd5, 2'd1, 1'b0}, 7'h00));
    send_item(pixel({4'd7, 2'd2, 1'b0}, {4'd5, 2'd1, 1'b0}, {4'd9, 2'd0, 1'b0}));
    send_item(pixel({4'd7, 2'd2, 1'b0}, {4'd5, 2'd1, 1'b1}, {4'd9, 2'd0, 1'b0}));
    send_item(pixel({4'd7, 2'd2, 1'b1}, {4'd5, 2'd1, 1'b1}, {4'd9, 2'd0, 1'b0}));
    send_item(pixel({4'd7, 2'd2, 1'b1}, {4'd5, 2'd1, 1'b1}, {4'd9, 2'd0, 1'b1}));
    // With shading off an operator code draws as a plain colour.
    send_item(pixel(7'h00, 7'h00, {OpHighlight, OpPalette, 1'b0}));
    wait_idle();

    // Shadow and highlight cases.
    apply_setting(1'b1, 6'd63, 1'b1, 3'd7);
    send_item(pixel({4'd7, 2'd2, 1'b0}, {4'd5, 2'd1, 1'b0}, 7'h00));
    send_item(pixel({4'd7, 2'd2, 1'b1}, 7'h00, 7'h00));
    send_item(pixel({4'd7, 2'd2, 1'b0}, 7'h00, {OpHighlight, OpPalette, 1'b0}));
    send_item(pixel({4'd7, 2'd2, 1'b1}, 7'h00, {OpHighlight, OpPalette, 1'b0}));
    send_item(pixel({4'd7, 2'd2, 1'b1}, 7'h00, {OpShadow, OpPalette, 1'b1}));
    send_item(pixel(7'h00, {4'd5, 2'd1, 1'b0}, {4'd9, 2'd0, 1'b1}));
    send_item(pixel(7'h00, 7'h00, 7'h00));
    wait_idle();

    // All layers masked off.
    apply_setting(1'b1, 6'd0, 1'b1, 3'd0);
    send_item(pixel(7'h7F, 7'h7F, 7'h7F));
    wait_idle();

    // Fill the whole palette with random colours.
    for (int i = 0; i < PalDepth; i++) begin
      send_item(pal_write(6'(i), 12'($urandom)));
    end
    wait_idle();

    // Random phases: idling pattern changes every two settings.
    for (int k = 0; k < 8; k++) begin
      case (k / 2)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 87; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 87; end
        default: begin in_idle_pct = 31; out_stall_pct = 31; end
      endcase
      case (k)
        0: apply_setting(1'b1, 6'd0, 1'b1, 3'd7);
        1: apply_setting(1'b1, 6'd63, 1'b0, 3'd0);
        2: apply_setting(1'b0, 6'd63, 1'b1, 3'd7);
        default: apply_setting($urandom_range(3) != 0, 6'($urandom), 1'($urandom),
                               3'($urandom));
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        send_item(random_item());
      end
      wait_idle();
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_layer_priority_mixer_shadow_highlight OK");
    end else begin
      $display("tb_layer_priority_mixer_shadow_highlight NOT OK");
    end
    $finish;
  end

endmodule
